### rtl/fatan2_pkg.sv
// shared types and constants for the fast atan2 pipeline
// no dependencies; used by every module under rtl/
package fatan2_pkg;

  // ratio z is q0.16 and can reach exactly 1.0, so it has one extra integer bit
  localparam int Z_FRAC = 16;
  localparam int Z_W    = Z_FRAC + 1;

  // angle datapath, signed q6.30 with headroom for -pi..2pi
  localparam int A_FRAC = 30;
  localparam int A_W    = 36;

  localparam int LIN_W  = 30;
  localparam int C2Z_W  = 27;
  localparam int BOW_W  = 31;
  localparam int POLY_W = 29;
  localparam int CORR_W = 28;
  localparam int BASE_W = 31;

  localparam int ANGLE_W = 16;

  // constants with 30 fraction bits (signed ones q6.30), rounded to nearest
  localparam logic [LIN_W-1:0]  K_PI4 = 30'd843314857;
  localparam logic [POLY_W-1:0] K_C1  = 29'd265965850;
  localparam logic [C2Z_W-1:0]  K_C2  = 27'd71189083;
  localparam logic signed [A_W-1:0] K_PI2 = 36'sd1686629713;
  localparam logic signed [A_W-1:0] K_PI  = 36'sd3373259426;
  localparam logic signed [A_W-1:0] K_2PI = 36'sd6746518852;

  localparam logic signed [A_W-1:0] OUT_MAX = 36'sd32767;
  localparam logic signed [A_W-1:0] OUT_MIN = -36'sd32768;

  // octant information that rides along with each sample
  typedef struct packed {
    logic zero;
    logic x_neg;
    logic y_neg;
    logic x_gt_y;
  } ctl_t;

endpackage

### rtl/fast_atan2_approx_top.sv
// top level of the fast atan2 pipeline: magnitude stage, divider, polynomial, output
// depends on fatan2_pkg, fatan2_div, fatan2_poly, fatan2_out
//
// Four-quadrant arctangent of a signed (x, y) pair, returned as signed Q4.12 radians
// (ANGLE_FRAC_BITS fraction bits). Fully pipelined: one pair is accepted every clock
// unless stalled, in SAMPLE_WIDTH-independent stages (1 magnitude stage, 17 divider
// stages producing one quotient bit each, 3 polynomial and fold stages, 1 output
// register). A stall from the output side freezes the whole pipeline and is passed
// straight back as input stall. range_mode selects -pi..pi (0) or 0..2pi (1); write it
// only while no transfers are in flight. Both components zero gives angle 0.
module fast_atan2_approx_top #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]         x_value_i,
  input  logic signed [SAMPLE_WIDTH-1:0]         y_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [fatan2_pkg::ANGLE_W-1:0]  angle_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic                                   cfg_range_mode_i
);

  logic                               en;
  logic                               range_mode_q;

  logic [SAMPLE_WIDTH-1:0]            ax;
  logic [SAMPLE_WIDTH-1:0]            ay;
  fatan2_pkg::ctl_t                   ctl_d;
  logic [SAMPLE_WIDTH-1:0]            lo_q;
  logic [SAMPLE_WIDTH-1:0]            hi_q;
  fatan2_pkg::ctl_t                   ctl_q;
  logic                               v0_q;

  logic                               div_valid;
  logic [fatan2_pkg::Z_W-1:0]         div_z;
  fatan2_pkg::ctl_t                   div_ctl;
  logic                               poly_valid;
  logic signed [fatan2_pkg::A_W-1:0]  poly_angle;

  // whole pipeline holds while a finished result waits
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      range_mode_q <= cfg_range_mode_i;
    end
  end

  // full-scale negative maps to 2^(w-1), which still fits unsigned
  assign ax = x_value_i[SAMPLE_WIDTH-1] ? (~x_value_i + 1'b1) : x_value_i;
  assign ay = y_value_i[SAMPLE_WIDTH-1] ? (~y_value_i + 1'b1) : y_value_i;

  always_comb begin
    ctl_d.zero   = (ax == '0) && (ay == '0);
    ctl_d.x_neg  = x_value_i[SAMPLE_WIDTH-1];
    ctl_d.y_neg  = y_value_i[SAMPLE_WIDTH-1];
    ctl_d.x_gt_y = ax > ay;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lo_q  <= ctl_d.x_gt_y ? ay : ax;
      hi_q  <= ctl_d.x_gt_y ? ax : ay;
      ctl_q <= ctl_d;
    end
  end

  fatan2_div #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .lo_i    (lo_q),
    .hi_i    (hi_q),
    .ctl_i   (ctl_q),
    .valid_o (div_valid),
    .z_o     (div_z),
    .ctl_o   (div_ctl)
  );

  fatan2_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .z_i     (div_z),
    .ctl_i   (div_ctl),
    .valid_o (poly_valid),
    .angle_o (poly_angle)
  );

  fatan2_out #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .range_mode_i (range_mode_q),
    .valid_i      (poly_valid),
    .angle_i      (poly_angle),
    .valid_o      (out_valid_o),
    .angle_o      (angle_o)
  );

endmodule

### rtl/fatan2_div.sv
// pipelined restoring divider: z = floor(lo * 2^16 / hi), one quotient bit per stage
// depends on fatan2_pkg
module fatan2_div #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [SAMPLE_WIDTH-1:0]      lo_i,
  input  logic [SAMPLE_WIDTH-1:0]      hi_i,
  input  fatan2_pkg::ctl_t             ctl_i,
  output logic                         valid_o,
  output logic [fatan2_pkg::Z_W-1:0]   z_o,
  output fatan2_pkg::ctl_t             ctl_o
);

  localparam int NS = fatan2_pkg::Z_W;

  logic [SAMPLE_WIDTH-1:0]    rem_q   [NS];
  logic [SAMPLE_WIDTH-1:0]    hi_q    [NS];
  logic [NS-1:0]              quot_q  [NS];
  fatan2_pkg::ctl_t           ctl_q   [NS];
  logic [NS-1:0]              valid_q;

  logic [SAMPLE_WIDTH:0]      trial   [NS];
  logic [SAMPLE_WIDTH:0]      diff    [NS];
  logic [NS-1:0]              ge;

  for (genvar j = 0; j < NS; j++) begin : g_stage
    if (j == 0) begin : g_first
      // leading bit: lo <= hi, so this only fires on equal magnitudes
      assign trial[j] = {1'b0, lo_i};
      assign ge[j]    = trial[j] >= {1'b0, hi_i};
      assign diff[j]  = trial[j] - {1'b0, hi_i};

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[j] <= 1'b0;
        end else if (en_i) begin
          valid_q[j] <= valid_i;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j]  <= ge[j] ? diff[j][SAMPLE_WIDTH-1:0] : trial[j][SAMPLE_WIDTH-1:0];
          hi_q[j]   <= hi_i;
          quot_q[j] <= {{(NS-1){1'b0}}, ge[j]};
          ctl_q[j]  <= ctl_i;
        end
      end
    end else begin : g_next
      assign trial[j] = {rem_q[j-1], 1'b0};
      assign ge[j]    = trial[j] >= {1'b0, hi_q[j-1]};
      assign diff[j]  = trial[j] - {1'b0, hi_q[j-1]};

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[j] <= 1'b0;
        end else if (en_i) begin
          valid_q[j] <= valid_q[j-1];
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j]  <= ge[j] ? diff[j][SAMPLE_WIDTH-1:0] : trial[j][SAMPLE_WIDTH-1:0];
          hi_q[j]   <= hi_q[j-1];
          quot_q[j] <= {quot_q[j-1][NS-2:0], ge[j]};
          ctl_q[j]  <= ctl_q[j-1];
        end
      end
    end
  end

  assign valid_o = valid_q[NS-1];
  assign z_o     = quot_q[NS-1];
  assign ctl_o   = ctl_q[NS-1];

endmodule

### rtl/fatan2_poly.sv
// base angle pi/4*z + z*(1-z)*(c1 + c2*z) in unsigned q1.30 and octant fold, three stages
// depends on fatan2_pkg
module fatan2_poly (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [fatan2_pkg::Z_W-1:0]          z_i,
  input  fatan2_pkg::ctl_t                    ctl_i,
  output logic                                valid_o,
  output logic signed [fatan2_pkg::A_W-1:0]   angle_o
);

  localparam int LIN_P_W  = fatan2_pkg::LIN_W + fatan2_pkg::Z_W;
  localparam int C2Z_P_W  = fatan2_pkg::C2Z_W + fatan2_pkg::Z_W;
  localparam int BOW_P_W  = 2 * fatan2_pkg::Z_W;
  localparam int CORR_P_W = fatan2_pkg::BOW_W + fatan2_pkg::POLY_W + 1;

  // stage 1: three independent products
  logic [LIN_P_W-1:0]              lin_prod;
  logic [C2Z_P_W-1:0]              c2z_prod;
  logic [BOW_P_W-1:0]              bow_prod;
  logic [fatan2_pkg::Z_W-1:0]      one_minus_z;
  logic [fatan2_pkg::LIN_W-1:0]    lin1_q;
  logic [fatan2_pkg::C2Z_W-1:0]    c2z_q;
  logic [fatan2_pkg::BOW_W-1:0]    bow_q;
  fatan2_pkg::ctl_t                ctl1_q;
  logic                            v1_q;

  assign one_minus_z = fatan2_pkg::Z_W'(1 << fatan2_pkg::Z_FRAC) - z_i;
  assign lin_prod    = LIN_P_W'(fatan2_pkg::K_PI4) * LIN_P_W'(z_i);
  assign c2z_prod    = C2Z_P_W'(fatan2_pkg::K_C2) * C2Z_P_W'(z_i);
  assign bow_prod    = BOW_P_W'(z_i) * BOW_P_W'(one_minus_z);

  // stage 2: correction term
  logic [fatan2_pkg::POLY_W-1:0]   poly;
  logic [CORR_P_W-1:0]             corr_prod;
  logic [fatan2_pkg::LIN_W-1:0]    lin2_q;
  logic [fatan2_pkg::CORR_W-1:0]   corr_q;
  fatan2_pkg::ctl_t                ctl2_q;
  logic                            v2_q;

  assign poly      = fatan2_pkg::K_C1 + fatan2_pkg::POLY_W'(c2z_q);
  assign corr_prod = CORR_P_W'(bow_q) * CORR_P_W'(poly);

  // stage 3: base angle and octant fold
  logic [fatan2_pkg::BASE_W-1:0]          base;
  logic signed [fatan2_pkg::A_W-1:0]      b;
  logic signed [fatan2_pkg::A_W-1:0]      fold_d;
  logic signed [fatan2_pkg::A_W-1:0]      fold_q;
  logic                                   v3_q;

  assign base = fatan2_pkg::BASE_W'(lin2_q) + fatan2_pkg::BASE_W'(corr_q);
  assign b    = signed'(fatan2_pkg::A_W'(base));

  always_comb begin
    if (ctl2_q.zero) begin
      fold_d = '0;
    end else if (ctl2_q.x_gt_y) begin
      if (!ctl2_q.x_neg) begin
        fold_d = ctl2_q.y_neg ? -b : b;
      end else begin
        fold_d = ctl2_q.y_neg ? (b - fatan2_pkg::K_PI) : (fatan2_pkg::K_PI - b);
      end
    end else begin
      // equal magnitudes land here too
      if (!ctl2_q.y_neg) begin
        fold_d = ctl2_q.x_neg ? (fatan2_pkg::K_PI2 + b) : (fatan2_pkg::K_PI2 - b);
      end else begin
        fold_d = ctl2_q.x_neg ? (-fatan2_pkg::K_PI2 - b) : (b - fatan2_pkg::K_PI2);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lin1_q <= lin_prod[fatan2_pkg::Z_FRAC +: fatan2_pkg::LIN_W];
      c2z_q  <= c2z_prod[fatan2_pkg::Z_FRAC +: fatan2_pkg::C2Z_W];
      bow_q  <= bow_prod[fatan2_pkg::BOW_W-1:0];
      ctl1_q <= ctl_i;
      lin2_q <= lin1_q;
      corr_q <= corr_prod[32 +: fatan2_pkg::CORR_W];
      ctl2_q <= ctl1_q;
      fold_q <= fold_d;
    end
  end

  assign valid_o = v3_q;
  assign angle_o = fold_q;

endmodule

### rtl/fatan2_out.sv
// output stage: optional 0..2pi shift, round half up to the output grid, saturate
// depends on fatan2_pkg
module fatan2_out #(
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                range_mode_i,
  input  logic                                valid_i,
  input  logic signed [fatan2_pkg::A_W-1:0]   angle_i,
  output logic                                valid_o,
  output logic signed [fatan2_pkg::ANGLE_W-1:0] angle_o
);

  localparam int SH = fatan2_pkg::A_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [fatan2_pkg::A_W-1:0] HALF = fatan2_pkg::A_W'(1) << (SH - 1);

  logic signed [fatan2_pkg::A_W-1:0]     wrapped;
  logic signed [fatan2_pkg::A_W-1:0]     rounded;
  logic signed [fatan2_pkg::ANGLE_W-1:0] angle_d;
  logic signed [fatan2_pkg::ANGLE_W-1:0] angle_q;
  logic                                  valid_q;

  always_comb begin
    wrapped = (range_mode_i && angle_i[fatan2_pkg::A_W-1]) ? (angle_i + fatan2_pkg::K_2PI)
                                                           : angle_i;
    rounded = (wrapped + HALF) >>> SH;
    if (rounded > fatan2_pkg::OUT_MAX) begin
      angle_d = fatan2_pkg::ANGLE_W'(fatan2_pkg::OUT_MAX);
    end else if (rounded < fatan2_pkg::OUT_MIN) begin
      angle_d = fatan2_pkg::ANGLE_W'(fatan2_pkg::OUT_MIN);
    end else begin
      angle_d = rounded[fatan2_pkg::ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= angle_d;
    end
  end

  assign valid_o = valid_q;
  assign angle_o = angle_q;

endmodule
